[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion macros. When SYNTHESIS is defined, each macro expands to
// nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define SFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFR_ASSERT(lbl, clk, rstn, prop, msg)
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hdl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, constants and the CRC-16 byte update for the framed receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 9;
  localparam int CRC_W  = 16;

  localparam logic [BYTE_W-1:0] START_BYTE      = 8'h02;
  localparam logic [CRC_W-1:0]  CRC_INIT        = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY        = 16'h1021;
  localparam logic [LEN_W-1:0]  MIN_FRAME_BYTES = 9'd8;
  localparam logic [LEN_W-1:0]  MAX_FRAME_BYTES = 9'd263;

  localparam logic [BYTE_W-1:0] CMD_RESET = 8'd131;
  localparam logic [LEN_W-1:0]  LEN_RESET = 9'd40;

  // configuration register indexes
  localparam logic CFG_IDX_CMD = 1'b0;
  localparam logic CFG_IDX_LEN = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_CMD  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              stored;
    logic [LEN_W-1:0]  position;
    logic              frame_end;
    logic              crc_ok;
  } res_t;

  // CRC-16, MSB first, one byte
  function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/serial_frame_receiver_crc16.sv]
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16
// Start-byte framed serial receiver with CRC-16 (poly 0x1021, init 0xFFFF) check.
// ----------------------------------------------------------------------------
// One byte in, one result out, one transaction per clock when both sides
// flow. A byte passes an input register, then the framer logic, then the
// output register. The rate is set by the framer state and CRC update,
// which update on each byte as it is passed to the output register.
// A stall on the result side holds the output register and then the input
// register, so back-pressure reaches in_stall in the same cycle.
// Every byte yields a result: stored=0 marks a byte dropped while hunting
// for 0x02 or a wrong command byte. position counts from 0 at the start
// byte. frame_end marks the last byte of a frame, and crc_ok says whether
// the CRC over all but the last two bytes matched them (high byte first).
// frame_length is clamped to 8..263. Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module serial_frame_receiver_crc16 #(
  parameter logic [sfr_pkg::LEN_W-1:0] MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_index,
  input  wire logic [sfr_pkg::LEN_W-1:0]   cfg_wdata,
  // input transactions
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [sfr_pkg::BYTE_W-1:0]  in_rx_byte,
  // result transactions
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [sfr_pkg::BYTE_W-1:0]       out_data_byte,
  output logic                             out_stored,
  output logic [sfr_pkg::LEN_W-1:0]        out_position,
  output logic                             out_frame_end,
  output logic                             out_crc_ok
);

  logic [sfr_pkg::BYTE_W-1:0] cmd_r;
  logic [sfr_pkg::LEN_W-1:0]  len_r;
  logic                       s1_valid_r;
  logic [sfr_pkg::BYTE_W-1:0] s1_byte_r;
  logic                       out_valid_r;
  sfr_pkg::res_t              out_r;
  sfr_pkg::res_t              res;
  logic                       out_free;
  logic                       s1_adv;
  logic                       in_take;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= sfr_pkg::CMD_RESET;
      len_r <= sfr_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sfr_pkg::CFG_IDX_CMD: cmd_r <= cfg_wdata[sfr_pkg::BYTE_W-1:0];
        sfr_pkg::CFG_IDX_LEN: len_r <= cfg_wdata;
        default:              len_r <= len_r;
      endcase
    end
  end

  // pipeline handshake: output slot frees when empty or being taken
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  sfr_framer #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_adv),
    .rx_byte (s1_byte_r),
    .cfg_cmd (cmd_r),
    .cfg_len (len_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_r.data_byte;
  assign out_stored    = out_r.stored;
  assign out_position  = out_r.position;
  assign out_frame_end = out_r.frame_end;
  assign out_crc_ok    = out_r.crc_ok;

  `SFR_ASSERT(a_take_fills, clk, rst_n, in_take |=> s1_valid_r, "accepted byte lost at input register")
  `SFR_ASSERT(a_hold_s1, clk, rst_n, s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_byte_r), "held input byte changed")
  `SFR_ASSERT(a_ok_at_end, clk, rst_n, out_valid_r && out_crc_ok |-> out_frame_end && out_stored, "crc_ok outside frame end")
  `SFR_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !s1_valid_r && !out_valid_r, "pipeline not empty after reset")

endmodule

`default_nettype wire

[hdl/sfr_framer.sv]
// ----------------------------------------------------------------------------
// sfr_framer
// Frame state machine and running CRC. Builds the result for the current
// byte and updates its state when the byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sfr_framer #(
  parameter logic [sfr_pkg::LEN_W-1:0] MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        fire,
  input  wire logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic [sfr_pkg::BYTE_W-1:0]  cfg_cmd,
  input  wire logic [sfr_pkg::LEN_W-1:0]   cfg_len,
  output sfr_pkg::res_t                    res
);

  sfr_pkg::phase_t               phase_r, phase_nxt;
  logic [sfr_pkg::LEN_W-1:0]     count_r, count_nxt;
  logic [sfr_pkg::CRC_W-1:0]     crc_r, crc_nxt;
  logic [sfr_pkg::BYTE_W-1:0]    crc_hi_r, crc_hi_nxt;
  logic [sfr_pkg::LEN_W-1:0]     len_eff;
  logic [sfr_pkg::LEN_W:0]       pos_p1;
  logic [sfr_pkg::LEN_W:0]       pos_p2;
  logic [sfr_pkg::CRC_W-1:0]     crc_fed;

  // clamp frame length to its legal range
  always_comb begin
    if (cfg_len < sfr_pkg::MIN_FRAME_BYTES) begin
      len_eff = sfr_pkg::MIN_FRAME_BYTES;
    end else if (cfg_len > MAX_FRAME_BYTES) begin
      len_eff = MAX_FRAME_BYTES;
    end else begin
      len_eff = cfg_len;
    end
  end

  assign pos_p1  = {1'b0, count_r} + 10'd1;
  assign pos_p2  = {1'b0, count_r} + 10'd2;
  assign crc_fed = sfr_pkg::crc16_feed(crc_r, rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sfr_pkg::PH_HUNT;
      count_r  <= '0;
      crc_r    <= sfr_pkg::CRC_INIT;
      crc_hi_r <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

  always_comb begin
    phase_nxt     = sfr_pkg::PH_HUNT;
    count_nxt     = '0;
    crc_nxt       = crc_r;
    crc_hi_nxt    = crc_hi_r;
    res.data_byte = rx_byte;
    res.stored    = 1'b0;
    res.position  = '0;
    res.frame_end = 1'b0;
    res.crc_ok    = 1'b0;
    case (phase_r)
      sfr_pkg::PH_CMD: begin
        if (rx_byte == cfg_cmd) begin
          res.stored   = 1'b1;
          res.position = 9'd1;
          crc_nxt      = crc_fed;
          count_nxt    = 9'd2;
          phase_nxt    = sfr_pkg::PH_BODY;
        end
      end
      sfr_pkg::PH_BODY: begin
        res.stored   = 1'b1;
        res.position = count_r;
        if (pos_p1 >= {1'b0, len_eff}) begin
          res.frame_end = 1'b1;
          res.crc_ok    = (crc_r == {crc_hi_r, rx_byte});
        end else begin
          if (pos_p2 < {1'b0, len_eff}) begin
            crc_nxt = crc_fed;
          end else begin
            crc_hi_nxt = rx_byte;
          end
          count_nxt = pos_p1[sfr_pkg::LEN_W-1:0];
          phase_nxt = sfr_pkg::PH_BODY;
        end
      end
      default: begin
        // hunting, unused code too
        if (rx_byte == sfr_pkg::START_BYTE) begin
          res.stored = 1'b1;
          crc_nxt    = sfr_pkg::crc16_feed(sfr_pkg::CRC_INIT, rx_byte);
          crc_hi_nxt = '0;
          count_nxt  = 9'd1;
          phase_nxt  = sfr_pkg::PH_CMD;
        end
      end
    endcase
  end

  `SFR_ASSERT(a_end_to_hunt, clk, rst_n, fire && res.frame_end |=> phase_r == sfr_pkg::PH_HUNT, "frame end did not return to hunting")
  `SFR_ASSERT(a_cmd_count, clk, rst_n, phase_r == sfr_pkg::PH_CMD |-> count_r == 9'd1, "command phase with wrong byte count")
  `SFR_ASSERT(a_body_count, clk, rst_n, phase_r == sfr_pkg::PH_BODY |-> count_r >= 9'd2 && count_r < MAX_FRAME_BYTES, "body byte count out of range")
  `SFR_ASSERT(a_start_to_cmd, clk, rst_n, fire && phase_r != sfr_pkg::PH_CMD && phase_r != sfr_pkg::PH_BODY && rx_byte == sfr_pkg::START_BYTE |=> phase_r == sfr_pkg::PH_CMD, "start byte not followed by command phase")

endmodule

`default_nettype wire
